>>> src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on each rising edge outside reset
`define FPC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("fpc assertion failed");

// Check a property on each rising edge, reset included
`define FPC_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("fpc assertion failed");

`endif

>>> src/fpc_pkg.sv
`default_nettype none

package fpc_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int DIFF_W      = 17;
    localparam int PROD_W      = 34;
    localparam int COV_W       = 33;
    localparam int IDX_W       = 6;
    localparam int LEN_W       = 7;
    localparam int MAX_LEN_DEF = 64;

    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(6);

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [DIFF_W-1:0]   t_diff;
    typedef logic signed [COV_W-1:0]    t_cov;
    typedef logic [IDX_W-1:0]           t_idx;
    typedef logic [LEN_W-1:0]           t_len;

endpackage

`default_nettype wire

>>> src/fpc_if.sv
`default_nettype none

interface fpc_cfg_if;
    import fpc_pkg::*;

    logic valid;
    logic ready;
    t_len frame_length;

    modport source (output valid, frame_length, input ready);
    modport sink   (input valid, frame_length, output ready);
endinterface

interface fpc_in_if;
    import fpc_pkg::*;

    logic    valid;
    logic    ready;
    t_sample sample;

    modport source (output valid, sample, input ready);
    modport sink   (input valid, sample, output ready);
endinterface

interface fpc_out_if;
    import fpc_pkg::*;

    logic valid;
    logic ready;
    t_cov cov_value;
    t_idx row_index;
    t_idx col_index;
    logic last_in_row;
    logic frame_done;

    modport source (output valid, cov_value, row_index, col_index, last_in_row, frame_done,
                    input ready);
    modport sink   (input valid, cov_value, row_index, col_index, last_in_row, frame_done,
                    output ready);
endinterface

`default_nettype wire

>>> src/fpc_ram.sv
`default_nettype none

module fpc_ram #(
    parameter int WIDTH = fpc_pkg::SAMPLE_W,
    parameter int DEPTH = fpc_pkg::MAX_LEN_DEF
) (
    input  logic                                          i_clk,
    input  logic                                          i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                              i_wdata,
    input  logic                                          i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                              o_rdata
);
    import fpc_pkg::*;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> src/frame_pair_covariance.sv
// Channel   Dir  Payload                                         Transfer
// i_cfg     in   frame_length                                    valid & ready
// i_in      in   sample                                          valid & ready
// o_out     out  cov_value row_index col_index last_in_row       valid & ready
//                frame_done
//
// Element i goes through the transfer, the previous-frame read and the first
// difference read, then gives i+1 results, one result per cycle while o_out
// is not stalled, from the single shared 17x17 multiplier.
// Reset is synchronous; a result waiting in the output register holds under
// back-pressure while the multiplier and the difference read halt with it.
`default_nettype none

module frame_pair_covariance #(
    parameter int MAX_LEN = fpc_pkg::MAX_LEN_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    fpc_cfg_if.sink    i_cfg,
    fpc_in_if.sink     i_in,
    fpc_out_if.source  o_out
);
    import fpc_pkg::*;

    localparam int   AW        = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam t_len MAX_LEN_L = LEN_W'(MAX_LEN);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_PREV = 2'd1;
    localparam logic [1:0] S_COL  = 2'd2;

    logic [1:0]    r_state;
    t_len          r_len;
    logic [AW-1:0] r_elem;
    logic          r_first;
    logic [AW-1:0] r_row;
    logic          r_fend;
    logic          r_zero_d;
    t_sample       r_sample;
    t_diff         r_d;
    logic [AW-1:0] r_issue;
    logic          r_issue_done;
    logic          r_have;
    logic [AW-1:0] r_col;

    logic          r_ovalid;
    t_cov          r_cov;
    t_idx          r_orow;
    t_idx          r_ocol;
    logic          r_olast;
    logic          r_ofdone;

    t_len                     eff_len;
    t_len                     next_pos;
    logic                     frame_end;
    logic                     in_acc;
    logic                     cfg_acc;
    logic                     load;
    logic                     issue;
    logic                     col_last;
    logic [SAMPLE_W-1:0]      prev_rd;
    logic [DIFF_W-1:0]        diff_rd;
    t_diff                    d_new;
    logic signed [PROD_W-1:0] prod;

    assign in_acc  = i_in.valid && i_in.ready;
    assign cfg_acc = i_cfg.valid && i_cfg.ready;

    always_comb begin
        if (r_len == '0) begin
            eff_len = LEN_W'(1);
        end else if (r_len > MAX_LEN_L) begin
            eff_len = MAX_LEN_L;
        end else begin
            eff_len = r_len;
        end
    end

    assign next_pos  = LEN_W'(r_elem) + LEN_W'(1);
    assign frame_end = (next_pos >= eff_len);

    assign d_new = r_zero_d ? '0
                            : (DIFF_W'($signed(prev_rd)) - DIFF_W'(r_sample));

    assign load     = (r_state == S_COL) && r_have && (!r_ovalid || o_out.ready);
    assign issue    = (r_state == S_COL) && !r_issue_done && (!r_have || load);
    assign col_last = (r_col == r_row);
    assign prod     = r_d * $signed(diff_rd);

    fpc_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_LEN)
    ) u_prev_ram (
        .i_clk   (i_clk),
        .i_we    (r_state == S_PREV),
        .i_waddr (r_row),
        .i_wdata (r_sample),
        .i_re    (in_acc),
        .i_raddr (r_elem),
        .o_rdata (prev_rd)
    );

    fpc_ram #(
        .WIDTH (DIFF_W),
        .DEPTH (MAX_LEN)
    ) u_diff_ram (
        .i_clk   (i_clk),
        .i_we    (r_state == S_PREV),
        .i_waddr (r_row),
        .i_wdata (d_new),
        .i_re    (issue),
        .i_raddr (r_issue),
        .o_rdata (diff_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_len        <= LEN_RESET;
            r_elem       <= '0;
            r_first      <= 1'b1;
            r_have       <= 1'b0;
            r_issue_done <= 1'b0;
            r_ovalid     <= 1'b0;
        end else begin
            if (cfg_acc) begin
                r_len <= i_cfg.frame_length;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_sample <= i_in.sample;
                        r_row    <= r_elem;
                        r_fend   <= frame_end;
                        r_zero_d <= r_first;
                        if (frame_end) begin
                            r_elem  <= '0;
                            r_first <= 1'b0;
                        end else begin
                            r_elem <= r_elem + AW'(1);
                        end
                        r_state <= S_PREV;
                    end
                end
                S_PREV: begin
                    r_d          <= d_new;
                    r_issue      <= '0;
                    r_issue_done <= 1'b0;
                    r_have       <= 1'b0;
                    r_state      <= S_COL;
                end
                S_COL: begin
                    if (issue) begin
                        r_col  <= r_issue;
                        r_have <= 1'b1;
                        if (r_issue == r_row) begin
                            r_issue_done <= 1'b1;
                        end else begin
                            r_issue <= r_issue + AW'(1);
                        end
                    end else if (load) begin
                        r_have <= 1'b0;
                    end
                    if (load && col_last) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            if (load) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cov    <= prod[COV_W-1:0];
            r_orow   <= IDX_W'(r_row);
            r_ocol   <= IDX_W'(r_col);
            r_olast  <= col_last;
            r_ofdone <= col_last && r_fend;
        end
    end

    assign i_cfg.ready       = 1'b1;
    assign i_in.ready        = (r_state == S_IDLE);
    assign o_out.valid       = r_ovalid;
    assign o_out.cov_value   = r_cov;
    assign o_out.row_index   = r_orow;
    assign o_out.col_index   = r_ocol;
    assign o_out.last_in_row = r_olast;
    assign o_out.frame_done  = r_ofdone;

endmodule

`default_nettype wire

>>> src/fpc_checker.sv
`default_nettype none
`include "assert_macros.svh"

module fpc_checker (
    input wire                 i_clk,
    input wire                 i_rst_n,
    input wire                 i_in_valid,
    input wire                 i_in_ready,
    input wire                 i_out_valid,
    input wire                 i_out_ready,
    input wire [fpc_pkg::IDX_W-1:0] i_row_index,
    input wire [fpc_pkg::IDX_W-1:0] i_col_index,
    input wire                 i_last_in_row,
    input wire                 i_frame_done
);
    import fpc_pkg::*;

    `FPC_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid)
    `FPC_ASSERT(a_in_busy, i_clk, i_rst_n, i_in_valid && i_in_ready |=> !i_in_ready)
    `FPC_ASSERT(a_col_le_row, i_clk, i_rst_n, i_out_valid |-> i_col_index <= i_row_index)
    `FPC_ASSERT(a_done_last, i_clk, i_rst_n, i_out_valid && i_frame_done |-> i_last_in_row && i_col_index == i_row_index)
    `FPC_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !i_out_valid)

endmodule

bind frame_pair_covariance fpc_checker u_fpc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_row_index   (o_out.row_index),
    .i_col_index   (o_out.col_index),
    .i_last_in_row (o_out.last_in_row),
    .i_frame_done  (o_out.frame_done)
);

`default_nettype wire

>>> test/tb.sv
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fpc_pkg::*;

    localparam int      IDLE_LIMIT   = 500;
    localparam int      MAX_ELEMS    = MAX_LEN_DEF;
    localparam int      RANDOM_ITEMS = 15;
    localparam t_sample SAMPLE_MAX   = 16'sh7FFF;
    localparam t_sample SAMPLE_MIN   = 16'sh8000;
    localparam t_len    LEN_ZERO     = 7'd0;
    localparam t_len    LEN_ONE      = 7'd1;
    localparam t_len    LEN_PAIR     = 7'd2;
    localparam t_len    LEN_FULL     = 7'd64;
    localparam t_len    LEN_TOP      = 7'd127;

    typedef struct {
        t_cov cov_value;
        t_idx row_index;
        t_idx col_index;
        logic last_in_row;
        logic frame_done;
    } t_cov_entry;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    fpc_cfg_if cfg_if ();
    fpc_in_if  in_if ();
    fpc_out_if out_if ();

    t_cov_entry pending_covs[$];
    t_sample    prev_samples[MAX_ELEMS] = '{default: '0};
    t_diff      row_diffs[MAX_ELEMS]    = '{default: '0};
    t_len       frame_len_reg           = LEN_RESET;
    int         elem_pos                = 0;
    logic       pairing_first           = 1'b1;

    int gap_pct      = 0;
    int stall_pct    = 0;
    int out_hold     = 0;
    int idle_cycles  = 0;
    int mismatches   = 0;
    int samples_sent = 0;

    always #5ns i_clk = ~i_clk;

    frame_pair_covariance u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    function automatic void predict_cov_row(input t_sample s);
        int         len;
        int         d;
        bit         frame_end;
        t_cov_entry e;
        len = int'(frame_len_reg);
        if (len == 0) begin
            len = 1;
        end
        if (len > MAX_ELEMS) begin
            len = MAX_ELEMS;
        end
        frame_end = (elem_pos + 1 >= len);
        d = pairing_first ? 0 : int'(prev_samples[elem_pos]) - int'(s);
        row_diffs[elem_pos]    = t_diff'(d);
        prev_samples[elem_pos] = s;
        for (int j = 0; j <= elem_pos; j++) begin
            e.cov_value   = t_cov'(longint'(d) * longint'(row_diffs[j]));
            e.row_index   = t_idx'(elem_pos);
            e.col_index   = t_idx'(j);
            e.last_in_row = (j == elem_pos);
            e.frame_done  = (j == elem_pos) && frame_end;
            pending_covs = {pending_covs, e};
        end
        if (frame_end) begin
            elem_pos      = 0;
            pairing_first = 1'b0;
        end else begin
            elem_pos++;
        end
    endfunction

    function automatic t_sample pick_sample();
        case ($urandom_range(0, 7))
            0: return SAMPLE_MAX;
            1: return SAMPLE_MIN;
            2: return prev_samples[elem_pos];
            default: return t_sample'($urandom);
        endcase
    endfunction

    function automatic void check_field(input string name, input logic signed [63:0] want,
                                        input logic signed [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    task automatic send_sample(input t_sample s);
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        in_if.valid  <= 1'b1;
        in_if.sample <= s;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        predict_cov_row(s);
        samples_sent++;
    endtask

    task automatic wait_until_idle();
        in_if.valid <= 1'b0;
        while (pending_covs.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_length(input t_len len);
        wait_until_idle();
        cfg_if.valid        <= 1'b1;
        cfg_if.frame_length <= len;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        cfg_if.valid  <= 1'b0;
        frame_len_reg = len;
    endtask

    // First frame pairs with itself; switching to an oversized length
    // mid-frame fills every stored element and must end the frame at 63.
    task automatic test_first_frame();
        gap_pct   = 30;
        stall_pct = 30;
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        repeat (3) send_sample(pick_sample());
        write_length(LEN_TOP);
        repeat (MAX_ELEMS - 5) send_sample(pick_sample());
    endtask

    task automatic test_extreme_diffs();
        gap_pct   = 0;
        stall_pct = 0;
        write_length(LEN_PAIR);
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
    endtask

    task automatic test_zero_length();
        gap_pct   = 30;
        stall_pct = 0;
        write_length(LEN_ZERO);
        repeat (3) send_sample(pick_sample());
    endtask

    task automatic test_length_change();
        gap_pct   = 0;
        stall_pct = 30;
        write_length(7'd10);
        repeat (7) send_sample(pick_sample());
        write_length(7'd3);
        repeat (2) send_sample(pick_sample());
        write_length(7'd5);
        repeat (2) send_sample(pick_sample());
    endtask

    task automatic test_full_length();
        gap_pct   = 30;
        stall_pct = 30;
        write_length(LEN_FULL);
        repeat (3) send_sample(pick_sample());
        write_length(LEN_ONE);
        repeat (2) send_sample(pick_sample());
    endtask

    task automatic test_random_frames();
        int   start;
        int   pick;
        int   n;
        int   eff;
        int   left;
        t_len len;
        start = samples_sent;
        while (samples_sent - start < RANDOM_ITEMS) begin
            gap_pct   = ($urandom_range(0, 2) == 0) ? 0 : 25;
            stall_pct = ($urandom_range(0, 2) == 0) ? 0 : 25;
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                len = t_len'($urandom_range(64, 127));
            end else if (pick == 1) begin
                len = LEN_ZERO;
            end else begin
                len = t_len'($urandom_range(1, 12));
            end
            write_length(len);
            eff = (len == 0) ? 1 : ((len > MAX_ELEMS) ? MAX_ELEMS : int'(len));
            n = (pick == 0) ? $urandom_range(8, MAX_ELEMS) : $urandom_range(1, 3 * eff);
            left = RANDOM_ITEMS - (samples_sent - start);
            if (n > left) begin
                n = left;
            end
            repeat (n) send_sample(pick_sample());
        end
    endtask

    task automatic test_final_stretch();
        gap_pct   = 0;
        stall_pct = 0;
        write_length(t_len'($urandom_range(1, 8)));
        repeat (10) send_sample(pick_sample());
    endtask

    always @(posedge i_clk) begin
        if (out_hold > 0) begin
            out_hold     <= out_hold - 1;
            out_if.ready <= 1'b0;
        end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
            out_hold     <= $urandom_range(0, 6);
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_cov_entry want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_covs.size() == 0) begin
                $error("unexpected transfer: row %0d col %0d cov %0d",
                       out_if.row_index, out_if.col_index, out_if.cov_value);
                mismatches++;
            end else begin
                want = pending_covs.pop_front();
                check_field("cov_value", want.cov_value, out_if.cov_value);
                check_field("row_index", want.row_index, out_if.row_index);
                check_field("col_index", want.col_index, out_if.col_index);
                check_field("last_in_row", want.last_in_row, out_if.last_in_row);
                check_field("frame_done", want.frame_done, out_if.frame_done);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)
                || (cfg_if.valid && cfg_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("frame_pair_covariance test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        cfg_if.valid        <= 1'b0;
        cfg_if.frame_length <= LEN_RESET;
        in_if.valid         <= 1'b0;
        in_if.sample        <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_first_frame();
        test_extreme_diffs();
        test_zero_length();
        test_length_change();
        test_full_length();
        test_random_frames();
        test_final_stretch();

        wait_until_idle();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && pending_covs.size() == 0) begin
            $display("frame_pair_covariance test passed");
        end else begin
            $display("frame_pair_covariance test failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
